// ===== hdl/rsti_pkg.sv =====
// Package for the radix string to integer unit.
// Holds the classified character type, the phase codes and the reset values
// of the configuration registers. It depends on nothing.
package rsti_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int VAL_W      = 64;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] REG_RADIX       = 2'd0;
    localparam logic [1:0] REG_DIGIT_COUNT = 2'd1;
    localparam logic [1:0] REG_DIGITS_LOW  = 2'd2;
    localparam logic [1:0] REG_DIGITS_HIGH = 2'd3;

    localparam logic [4:0]  RST_RADIX       = 5'd10;
    localparam logic [4:0]  RST_DIGIT_COUNT = 5'd10;
    localparam logic [63:0] RST_DIGITS_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] RST_DIGITS_HIGH = 64'h0000_0000_0000_3938;

    typedef enum logic [3:0] {
        PH_WS   = 4'b0001,
        PH_SIGN = 4'b0010,
        PH_DIG  = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic             first;
        logic             space;
        logic             minus;
        logic             plus;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_tok;

endpackage

// ===== hdl/radix_string_to_integer_unit.sv =====
// Top level of the radix string to integer unit: configuration registers and
// the front and back ends joined by a short queue.
// Depends on rsti_pkg, rsti_front and rsti_back.
//
// Usage: the input channel (i_valid, o_ready) takes one character per item in
// i_ch; i_first set starts a new string with this character. The output
// channel (o_valid, i_ready) carries o_value, the signed 64-bit result, one
// per number, posted at the first character not a leading blank, sign or digit.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while
// the unit is idle: radix, digit count, low and high alphabet words.
// Throughput is one item per cycle unless the receiver stalls. An ending item
// is classified into the queue register, then taken by the multiply-add stage
// of the back end, which updates the accumulator once per item and sets the
// pace; the result goes to the output register. Reset loads the default
// decimal alphabet and radix, empties the queue and awaits a first character.
// When the receiver stalls, the result holds in the output register, the
// back end stops draining the queue, and o_ready falls once two items wait.
module radix_string_to_integer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_ch,
    input  logic                              i_first,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rsti_pkg::VAL_W-1:0] o_value,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [rsti_pkg::VAL_W-1:0]        i_cfg_data
);

    logic [4:0]                  r_radix;
    logic [rsti_pkg::CNT_W-1:0]  r_digit_count;
    logic [rsti_pkg::VAL_W-1:0]  r_digits_low;
    logic [rsti_pkg::VAL_W-1:0]  r_digits_high;
    logic                        w_qvalid;
    rsti_pkg::t_tok              w_qtok;
    logic                        w_qpop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= rsti_pkg::RST_RADIX;
            r_digit_count <= rsti_pkg::RST_DIGIT_COUNT;
            r_digits_low  <= rsti_pkg::RST_DIGITS_LOW;
            r_digits_high <= rsti_pkg::RST_DIGITS_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rsti_pkg::REG_RADIX:       r_radix       <= i_cfg_data[4:0];
                rsti_pkg::REG_DIGIT_COUNT: r_digit_count <= i_cfg_data[4:0];
                rsti_pkg::REG_DIGITS_LOW:  r_digits_low  <= i_cfg_data;
                rsti_pkg::REG_DIGITS_HIGH: r_digits_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rsti_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ch          (i_ch),
        .i_first       (i_first),
        .i_digit_count (r_digit_count),
        .i_alphabet    ({r_digits_high, r_digits_low}),
        .o_qvalid      (w_qvalid),
        .o_qtok        (w_qtok),
        .i_qpop        (w_qpop)
    );

    rsti_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (w_qvalid),
        .i_qtok   (w_qtok),
        .o_qpop   (w_qpop),
        .i_radix  (r_radix),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_value  (o_value)
    );

endmodule

// ===== hdl/rsti_front.sv =====
// Front end of the radix string to integer unit: takes input items, classifies
// each character against the whitespace set, the signs and the digit alphabet,
// and queues the result. Depends on rsti_pkg.
module rsti_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_ch,
    input  logic                        i_first,
    input  logic [rsti_pkg::CNT_W-1:0]  i_digit_count,
    input  logic [2*rsti_pkg::VAL_W-1:0] i_alphabet,
    output logic                        o_qvalid,
    output rsti_pkg::t_tok              o_qtok,
    input  logic                        i_qpop
);

    rsti_pkg::t_tok                     w_tok;
    logic [rsti_pkg::CNT_W-1:0]         w_limit;
    logic                               w_push;
    logic [7:0]                         w_entry;

    rsti_pkg::t_tok                     r_q [rsti_pkg::Q_DEPTH];
    logic [rsti_pkg::Q_PTR_W-1:0]       r_wr;
    logic [rsti_pkg::Q_PTR_W-1:0]       r_rd;
    logic [rsti_pkg::Q_CNT_W-1:0]       r_cnt;
    logic [rsti_pkg::Q_CNT_W-1:0]       n_cnt;

    always_comb begin
        w_limit = (i_digit_count > rsti_pkg::CNT_W'(rsti_pkg::MAX_DIGITS))
                ? rsti_pkg::CNT_W'(rsti_pkg::MAX_DIGITS) : i_digit_count;
        w_tok.first = i_first;
        w_tok.space = (i_ch == rsti_pkg::CH_SPACE) || (i_ch == rsti_pkg::CH_LF) ||
                      (i_ch == rsti_pkg::CH_TAB) || (i_ch == rsti_pkg::CH_CR) ||
                      (i_ch == rsti_pkg::CH_VT) || (i_ch == rsti_pkg::CH_FF);
        w_tok.minus = (i_ch == rsti_pkg::CH_MINUS);
        w_tok.plus  = (i_ch == rsti_pkg::CH_PLUS);
        w_tok.hit   = 1'b0;
        w_tok.idx   = '0;
        w_entry     = '0;
        for (int k = rsti_pkg::MAX_DIGITS - 1; k >= 0; k--) begin
            w_entry = i_alphabet[8*k +: 8];
            if ((rsti_pkg::CNT_W'(k) < w_limit) && (w_entry != rsti_pkg::CH_NUL) &&
                (w_entry == i_ch)) begin
                w_tok.hit = 1'b1;
                w_tok.idx = rsti_pkg::IDX_W'(k);
            end
        end
    end

    assign o_ready  = (r_cnt != rsti_pkg::Q_CNT_W'(rsti_pkg::Q_DEPTH));
    assign w_push   = i_valid && o_ready;
    assign o_qvalid = (r_cnt != '0);
    assign o_qtok   = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_qpop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && i_qpop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_qpop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rsti_pkg::Q_CNT_W'(rsti_pkg::Q_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_qpop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("Queue count did not grow on a push.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qpop |-> (r_cnt != '0))
        else $error("Queue popped while empty.");

endmodule

// ===== hdl/rsti_back.sv =====
// Back end of the radix string to integer unit: runs the parse phases, the
// accumulator multiply-add and the output register. Depends on rsti_pkg.
module rsti_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_qvalid,
    input  rsti_pkg::t_tok                i_qtok,
    output logic                          o_qpop,
    input  logic [4:0]                    i_radix,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [rsti_pkg::VAL_W-1:0] o_value
);

    rsti_pkg::t_phase               r_phase;
    rsti_pkg::t_phase               n_phase;
    rsti_pkg::t_phase               w_ph;
    logic                           r_par;
    logic                           n_par;
    logic                           w_par;
    logic [rsti_pkg::VAL_W-1:0]     r_acc;
    logic [rsti_pkg::VAL_W-1:0]     n_acc;
    logic [rsti_pkg::VAL_W-1:0]     w_acc;
    logic                           r_oval;
    logic                           n_oval;
    logic [rsti_pkg::VAL_W-1:0]     r_odata;
    logic [rsti_pkg::VAL_W-1:0]     n_odata;
    logic                           w_pop;
    logic                           w_pre;
    logic                           w_emit;
    logic                           w_dig;

    assign w_pop   = i_qvalid && (!r_oval || i_ready);
    assign o_qpop  = w_pop;
    assign o_valid = r_oval;
    assign o_value = r_odata;

    always_comb begin
        w_ph   = i_qtok.first ? rsti_pkg::PH_WS : r_phase;
        w_par  = i_qtok.first ? 1'b0 : r_par;
        w_acc  = i_qtok.first ? '0 : r_acc;
        w_pre  = (w_ph == rsti_pkg::PH_WS) || (w_ph == rsti_pkg::PH_SIGN);
        w_emit = 1'b0;
        w_dig  = 1'b0;
        n_phase = w_ph;
        n_par   = w_par;
        n_acc   = w_acc;
        if (w_ph == rsti_pkg::PH_DONE) begin
            n_phase = rsti_pkg::PH_DONE;
        end else if ((w_ph == rsti_pkg::PH_WS) && i_qtok.space) begin
            n_phase = rsti_pkg::PH_WS;
        end else if (w_pre && i_qtok.minus) begin
            n_phase = rsti_pkg::PH_SIGN;
            n_par   = ~w_par;
        end else if (w_pre && i_qtok.plus) begin
            n_phase = rsti_pkg::PH_SIGN;
        end else if (i_qtok.hit) begin
            w_dig   = 1'b1;
            n_phase = rsti_pkg::PH_DIG;
            n_acc   = rsti_pkg::VAL_W'(w_acc * {{(rsti_pkg::VAL_W-5){1'b0}}, i_radix})
                    + {{(rsti_pkg::VAL_W-rsti_pkg::IDX_W){1'b0}}, i_qtok.idx};
        end else begin
            w_emit  = 1'b1;
            n_phase = rsti_pkg::PH_DONE;
        end
    end

    always_comb begin
        n_oval  = r_oval;
        n_odata = r_odata;
        if (w_pop && w_emit) begin
            n_oval  = 1'b1;
            n_odata = w_par ? (rsti_pkg::VAL_W'(0) - w_acc) : w_acc;
        end else if (i_ready) begin
            n_oval  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        if (w_pop) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rsti_pkg::PH_DONE;
            r_par   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_oval <= n_oval;
            if (w_pop) begin
                r_phase <= n_phase;
                r_par   <= n_par;
            end
        end
    end

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_emit) |=> (r_phase == rsti_pkg::PH_DONE) && r_oval)
        else $error("Ending a number did not post a result and close the parse.");

    a_rise_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_oval) |-> $past(w_pop))
        else $error("Result appeared without an item taken from the queue.");

    a_dig_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_dig) |=> (r_phase == rsti_pkg::PH_DIG))
        else $error("A digit did not leave the parse in the digit phase.");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_qtok.first && (r_phase == rsti_pkg::PH_DONE)) |-> !w_emit)
        else $error("An item after the end of a number produced a result.");

endmodule

// ===== dv/tb.sv =====
// Testbench for radix_string_to_integer_unit: a directed table, then random strings
// under several alphabets and radices, checked against a parser model kept here.
// Depends on rsti_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb;

    localparam int PHASE_ITEMS  = 66;
    localparam int N_SETUPS     = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic [7:0]  ch;
        logic        first;
        logic        typed;
        logic [63:0] val;
    } t_row;

    typedef struct {
        logic [4:0]  radix;
        logic [4:0]  count;
        logic [63:0] lo;
        logic [63:0] hi;
        bit          rand_alpha;
        int          tx_pct;
        int          rx_pct;
    } t_setup;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [7:0]                        i_ch = 8'h00;
    logic                              i_first = 1'b0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [rsti_pkg::VAL_W-1:0] o_value;
    logic                              i_cfg_we = 1'b0;
    logic [1:0]                        i_cfg_idx = rsti_pkg::REG_RADIX;
    logic [rsti_pkg::VAL_W-1:0]        i_cfg_data = '0;

    // Model of the parser and its configuration.
    logic [4:0]               cfg_radix = rsti_pkg::RST_RADIX;
    logic [4:0]               cfg_count = rsti_pkg::RST_DIGIT_COUNT;
    logic [63:0]              cfg_lo = rsti_pkg::RST_DIGITS_LOW;
    logic [63:0]              cfg_hi = rsti_pkg::RST_DIGITS_HIGH;
    rsti_pkg::t_phase         psr_phase = rsti_pkg::PH_DONE;
    logic                     psr_neg = 1'b0;
    logic [63:0]              psr_acc = '0;

    logic signed [63:0]       value_q[$];
    int                       err_cnt = 0;
    int                       items_sent = 0;
    int                       tx_idle_pct = 0;
    int                       rx_stall_pct = 0;
    int                       cycle_cnt = 0;
    int                       hold_left = 0;
    bit                       long_hold_req = 1'b0;
    bit                       long_hold_done = 1'b0;

    radix_string_to_integer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_ch       (i_ch),
        .i_first    (i_first),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value    (o_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] alpha_char(input int k);
        return (k < 8) ? cfg_lo[8*k +: 8] : cfg_hi[8*(k-8) +: 8];
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c inside {rsti_pkg::CH_SPACE, rsti_pkg::CH_LF, rsti_pkg::CH_TAB,
                         rsti_pkg::CH_CR, rsti_pkg::CH_VT, rsti_pkg::CH_FF};
    endfunction

    function automatic int alpha_limit();
        return (cfg_count > rsti_pkg::MAX_DIGITS) ? rsti_pkg::MAX_DIGITS : int'(cfg_count);
    endfunction

    function automatic bit alpha_lookup(input logic [7:0] c, output logic [3:0] pos);
        logic [7:0] e;
        pos = '0;
        if (c == rsti_pkg::CH_NUL) return 1'b0;
        for (int k = 0; k < alpha_limit(); k++) begin
            e = alpha_char(k);
            if (e != rsti_pkg::CH_NUL && e == c) begin
                pos = 4'(k);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input logic first,
                                      output logic [63:0] val);
        logic [3:0] pos;
        val = '0;
        if (first) begin
            psr_phase = rsti_pkg::PH_WS;
            psr_neg = 1'b0;
            psr_acc = '0;
        end
        if (psr_phase == rsti_pkg::PH_DONE) return 1'b0;
        if (psr_phase == rsti_pkg::PH_WS) begin
            if (is_blank(c)) return 1'b0;
            psr_phase = rsti_pkg::PH_SIGN;
        end
        if (psr_phase == rsti_pkg::PH_SIGN) begin
            if (c == rsti_pkg::CH_MINUS) begin
                psr_neg = ~psr_neg;
                return 1'b0;
            end
            if (c == rsti_pkg::CH_PLUS) return 1'b0;
            psr_phase = rsti_pkg::PH_DIG;
        end
        if (alpha_lookup(c, pos)) begin
            psr_acc = psr_acc * {59'd0, cfg_radix} + {60'd0, pos};
            return 1'b0;
        end
        val = psr_neg ? -psr_acc : psr_acc;
        psr_phase = rsti_pkg::PH_DONE;
        return 1'b1;
    endfunction

    task automatic push_char(input logic [7:0] c, input logic first,
                             input logic typed, input logic [63:0] typed_val);
        logic [63:0] val;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        i_first <= first;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (parse_char(c, first, val)) value_q.push_back(typed ? typed_val : val);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(5))
            0: return rsti_pkg::CH_SPACE;
            1: return rsti_pkg::CH_LF;
            2: return rsti_pkg::CH_TAB;
            3: return rsti_pkg::CH_CR;
            4: return rsti_pkg::CH_VT;
            default: return rsti_pkg::CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        logic [7:0] e;
        for (int tries = 0; tries < 8 && alpha_limit() > 0; tries++) begin
            e = alpha_char($urandom_range(alpha_limit() - 1));
            if (e != rsti_pkg::CH_NUL) return e;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_end();
        case ($urandom_range(5))
            0: return rsti_pkg::CH_NUL;
            1: return pick_blank();
            2: return $urandom_range(1) ? rsti_pkg::CH_MINUS : rsti_pkg::CH_PLUS;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_string();
        logic lead;
        int   n_dig;
        lead = 1'b1;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6))
                push_char(8'($urandom_range(255)), $urandom_range(2) == 0, 1'b0, '0);
            return;
        end
        repeat (($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0) begin
            push_char(pick_blank(), lead, 1'b0, '0);
            lead = 1'b0;
        end
        repeat (($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0) begin
            push_char($urandom_range(1) ? rsti_pkg::CH_MINUS : rsti_pkg::CH_PLUS,
                      lead, 1'b0, '0);
            lead = 1'b0;
        end
        n_dig = ($urandom_range(4) == 0) ? $urandom_range(12, 22) : $urandom_range(0, 6);
        repeat (n_dig) begin
            push_char(pick_digit(), lead, 1'b0, '0);
            lead = 1'b0;
        end
        if ($urandom_range(9) != 0) push_char(pick_end(), lead, 1'b0, '0);
        repeat ($urandom_range(2)) push_char(8'($urandom_range(255)), 1'b0, 1'b0, '0);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (value_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (value_q.size() != 0) begin
            $display("%0t: %0d expected values never arrived, oldest %0d",
                     $time, value_q.size(), value_q[0]);
            err_cnt++;
            value_q.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            rsti_pkg::REG_RADIX:       cfg_radix = data[4:0];
            rsti_pkg::REG_DIGIT_COUNT: cfg_count = data[4:0];
            rsti_pkg::REG_DIGITS_LOW:  cfg_lo = data;
            default:                   cfg_hi = data;
        endcase
    endtask

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(3) == 0) w[8*k +: 8] = rsti_pkg::CH_NUL;
            else if ($urandom_range(4) == 0) w[8*k +: 8] = w[7:0];
        end
        return w;
    endfunction

    // Checks each result against the oldest expected value and drives i_ready, with random stalls and one long hold.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (value_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d", $time, o_value);
                err_cnt++;
            end else begin
                if (o_value !== value_q[0]) begin
                    $display("%0t: value mismatch, expected %0d, got %0d",
                             $time, value_q[0], o_value);
                    err_cnt++;
                end
                void'(value_q.pop_front());
            end
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_row   dir_rows [24];
        t_setup setups [N_SETUPS];
        int     phase_start;
        logic [63:0] lo;
        logic [63:0] hi;

        dir_rows = '{
            '{"x",                1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_SPACE, 1'b1, 1'b0, 64'd0},
            '{rsti_pkg::CH_TAB,   1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_LF,    1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_CR,    1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_VT,    1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_FF,    1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_MINUS, 1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_MINUS, 1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_MINUS, 1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_PLUS,  1'b0, 1'b0, 64'd0},
            '{"4",                1'b0, 1'b0, 64'd0},
            '{"2",                1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_SPACE, 1'b0, 1'b1, -64'sd42},
            '{"z",                1'b0, 1'b0, 64'd0},
            '{"9",                1'b1, 1'b0, 64'd0},
            '{"9",                1'b0, 1'b0, 64'd0},
            '{rsti_pkg::CH_NUL,   1'b0, 1'b1, 64'd99},
            '{rsti_pkg::CH_MINUS, 1'b1, 1'b0, 64'd0},
            '{rsti_pkg::CH_SPACE, 1'b0, 1'b1, 64'd0},
            '{"1",                1'b1, 1'b0, 64'd0},
            '{"2",                1'b1, 1'b0, 64'd0},
            '{8'hFF,              1'b0, 1'b1, 64'd2},
            '{rsti_pkg::CH_NUL,   1'b1, 1'b1, 64'd0}
        };

        setups[0] = '{5'd10, 5'd10, rsti_pkg::RST_DIGITS_LOW, rsti_pkg::RST_DIGITS_HIGH,
                      1'b0, 0, 0};
        setups[1] = '{5'd16, 5'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938,
                      1'b0, 75, 0};
        setups[2] = '{5'd2, 5'd2, 64'h3130, 64'h0, 1'b0, 0, 75};
        setups[3] = '{5'd0, 5'd31, 64'h0, 64'h0, 1'b1, 23, 23};
        setups[4] = '{5'd1, 5'd0, 64'h0, '1, 1'b0, 0, 0};
        setups[5] = '{5'd31, 5'd16, 64'h0, 64'h0, 1'b1, 75, 0};
        setups[6] = '{5'd8, 5'd17, 64'h0, 64'h0, 1'b1, 0, 75};
        setups[7] = '{5'd16, 5'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938,
                      1'b0, 23, 23};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings under the reset configuration.
        foreach (dir_rows[r])
            push_char(dir_rows[r].ch, dir_rows[r].first, dir_rows[r].typed, dir_rows[r].val);
        i_valid <= 1'b0;
        drain();

        for (int s = 0; s < N_SETUPS; s++) begin
            lo = setups[s].rand_alpha ? rand_word() : setups[s].lo;
            hi = setups[s].rand_alpha ? rand_word() : setups[s].hi;
            write_cfg(rsti_pkg::REG_RADIX, {$urandom, 27'($urandom_range(32'h07FF_FFFF)),
                                            setups[s].radix});
            write_cfg(rsti_pkg::REG_DIGIT_COUNT, {$urandom,
                                                  27'($urandom_range(32'h07FF_FFFF)),
                                                  setups[s].count});
            write_cfg(rsti_pkg::REG_DIGITS_LOW, lo);
            write_cfg(rsti_pkg::REG_DIGITS_HIGH, hi);
            i_cfg_we <= 1'b0;
            tx_idle_pct = setups[s].tx_pct;
            rx_stall_pct = setups[s].rx_pct;
            if (s == 6) long_hold_req = 1'b1;
            @(posedge i_clk);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_string();
            i_valid <= 1'b0;
            drain();
        end

        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
